>>> design/bpid_pkg.sv
// ============================================================================
// bpid_pkg: shared constants for the banded PID controller
// Holds the mode codes, input kind codes, register indexes and the reset
// values of the configuration registers.
// ============================================================================
`default_nettype none

package bpid_pkg;

    // Mode code of the controller state machine
    typedef logic [2:0] mode_code_t;
    // Kind of an input item
    typedef logic [1:0] kind_code_t;
    // Configuration register index
    typedef logic [2:0] reg_index_t;

    localparam mode_code_t MODE_INIT  = 3'd0;
    localparam mode_code_t MODE_BELOW = 3'd1;
    localparam mode_code_t MODE_ABOVE = 3'd2;
    localparam mode_code_t MODE_ONTGT = 3'd3;
    localparam mode_code_t MODE_STAB  = 3'd4;
    localparam mode_code_t MODE_DIS   = 3'd5;

    localparam kind_code_t KIND_STEP    = 2'd0;
    localparam kind_code_t KIND_ENABLE  = 2'd1;
    localparam kind_code_t KIND_DISABLE = 2'd2;
    localparam kind_code_t KIND_CLEAR   = 2'd3;

    localparam reg_index_t REG_GAIN_PROP       = 3'd0;
    localparam reg_index_t REG_GAIN_INTEG      = 3'd1;
    localparam reg_index_t REG_GAIN_DERIV      = 3'd2;
    localparam reg_index_t REG_ERROR_BANDS     = 3'd3;
    localparam reg_index_t REG_INTEGRAL_LIMITS = 3'd4;
    localparam reg_index_t REG_OUTPUT_RANGE    = 3'd5;
    localparam reg_index_t REG_INPUT_RANGE     = 3'd6;
    localparam reg_index_t REG_STEP_LIMITS     = 3'd7;

    // Width of the configuration write data (widest register)
    localparam int CFG_DATA_W = 48;

    // Reset values: range -1.0 .. 1.0, integral max 1.0, band 1.0,
    // ten on-target steps, increment cap 82 LSB
    localparam logic [15:0] RST_IMAX     = 16'h1000;
    localparam logic [15:0] RST_RANGE_LO = 16'hF000;
    localparam logic [15:0] RST_RANGE_HI = 16'h1000;
    localparam logic [15:0] RST_BAND     = 16'h1000;
    localparam logic [15:0] RST_STEPS    = 16'd10;
    localparam logic [15:0] RST_INC_CAP  = 16'd82;

endpackage : bpid_pkg

`default_nettype wire

>>> design/banded_pid_controller_unit.sv
// ============================================================================
// banded_pid_controller_unit: PID step with mode tracking and anti-windup
// One result per item; a control step runs clamp, error, band mode machine, P + I + D,
// dead band and output clamp, all in Q4.12 with Q8.8 gains.
// ============================================================================
//
// Usage:
//  - Input channel (in_valid / in_stall) carries kind, measured and target.
//    Each transfer yields exactly one result on the output channel
//    (out_valid / out_stall) with drive, drive_valid, error_now and status.
//  - Timing: the item is first captured in the input register, then the full
//    step is computed in one pass into the result register, where out_valid
//    rises. Throughput is one item per cycle while the receiver does not
//    stall; the controller state (mode, error sum, last error, settle
//    count) updates when an item moves from the input register into the
//    result register.
//  - When the receiver stalls, the result register holds; the input register
//    still takes one more item, and in_stall rises only when both are full.
//  - Configuration is a write port (cfg_write, cfg_index, cfg_data); write
//    only while no item is in flight. Range writes with min >= max are
//    dropped.
//  - Reset (rst_n low, asynchronous) empties both registers, restores the
//    configuration defaults and puts the mode machine in initialize.
//
`default_nettype none

module banded_pid_controller_unit
    import bpid_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,

    input  wire logic                   cfg_write,
    input  wire logic [2:0]             cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data,

    input  wire logic                   in_valid,
    output logic                        in_stall,
    input  wire logic [1:0]             kind,
    input  wire logic signed [15:0]     measured,
    input  wire logic signed [15:0]     target,

    output logic                        out_valid,
    input  wire logic                   out_stall,
    output logic signed [15:0]          drive,
    output logic                        drive_valid,
    output logic signed [16:0]          error_now,
    output logic                        at_target,
    output logic                        stabilized,
    output logic                        enabled
);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic signed [15:0] gain_prop_reg, gain_integ_reg, gain_deriv_reg;
    logic [15:0]        eps_reg, stat_reg;
    logic [15:0]        imax_reg, thr_reg;
    logic               thr_en_reg;
    logic signed [15:0] out_min_reg, out_max_reg;
    logic signed [15:0] in_min_reg, in_max_reg;
    logic [15:0]        band_reg, steps_reg, inc_reg;

    logic signed [15:0] cfg_lo, cfg_hi;
    logic               cfg_range_ok;

    assign cfg_lo       = $signed(cfg_data[15:0]);
    assign cfg_hi       = $signed(cfg_data[31:16]);
    assign cfg_range_ok = cfg_lo < cfg_hi;

    // Write one register per transfer; drop ranges with min >= max
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_prop_reg  <= '0;
            gain_integ_reg <= '0;
            gain_deriv_reg <= '0;
            eps_reg        <= '0;
            stat_reg       <= '0;
            imax_reg       <= RST_IMAX;
            thr_reg        <= '0;
            thr_en_reg     <= 1'b0;
            out_min_reg    <= RST_RANGE_LO;
            out_max_reg    <= RST_RANGE_HI;
            in_min_reg     <= RST_RANGE_LO;
            in_max_reg     <= RST_RANGE_HI;
            band_reg       <= RST_BAND;
            steps_reg      <= RST_STEPS;
            inc_reg        <= RST_INC_CAP;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_GAIN_PROP:  gain_prop_reg  <= $signed(cfg_data[15:0]);
                REG_GAIN_INTEG: gain_integ_reg <= $signed(cfg_data[15:0]);
                REG_GAIN_DERIV: gain_deriv_reg <= $signed(cfg_data[15:0]);
                REG_ERROR_BANDS:
                begin
                    eps_reg  <= cfg_data[15:0];
                    stat_reg <= cfg_data[31:16];
                end
                REG_INTEGRAL_LIMITS:
                begin
                    imax_reg   <= cfg_data[15:0];
                    thr_reg    <= cfg_data[31:16];
                    thr_en_reg <= cfg_data[32];
                end
                REG_OUTPUT_RANGE:
                begin
                    if (cfg_range_ok)
                    begin
                        out_min_reg <= cfg_lo;
                        out_max_reg <= cfg_hi;
                    end
                end
                REG_INPUT_RANGE:
                begin
                    if (cfg_range_ok)
                    begin
                        in_min_reg <= cfg_lo;
                        in_max_reg <= cfg_hi;
                    end
                end
                REG_STEP_LIMITS:
                begin
                    band_reg  <= cfg_data[15:0];
                    steps_reg <= cfg_data[31:16];
                    inc_reg   <= cfg_data[47:32];
                end
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Input register and flow control
    // ------------------------------------------------------------------
    logic               s1_valid_reg;
    kind_code_t         s1_kind_reg;
    logic signed [15:0] s1_measured_reg, s1_target_reg;
    logic               out_valid_reg;
    logic               advance;

    // Move the input register forward when the result register frees up
    assign advance  = !out_valid_reg || !out_stall;
    assign in_stall = s1_valid_reg && !advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            s1_kind_reg     <= kind;
            s1_measured_reg <= measured;
            s1_target_reg   <= target;
        end
    end

    // ------------------------------------------------------------------
    // Controller state
    // ------------------------------------------------------------------
    mode_code_t         mode_reg, mode_next;
    logic signed [31:0] error_sum_reg, error_sum_next;
    logic signed [16:0] last_error_reg, last_error_next;
    logic               dba_reg, dba_next;
    logic [15:0]        settle_reg, settle_next;

    // ------------------------------------------------------------------
    // Error and band compares
    // ------------------------------------------------------------------
    logic signed [15:0] pv;
    logic signed [16:0] err;
    logic signed [17:0] err18, eps18, neps18, stat18, nstat18, inc18, ninc18;
    logic signed [17:0] thr18, nthr18;
    logic               inband, ge_eps, le_neps;

    // Clamp the measurement and form the error
    always_comb
    begin
        if (s1_measured_reg > in_max_reg)
            pv = in_max_reg;
        else if (s1_measured_reg < in_min_reg)
            pv = in_min_reg;
        else
            pv = s1_measured_reg;
    end

    assign err     = 17'(s1_target_reg) - 17'(pv);
    assign err18   = 18'(err);
    assign eps18   = $signed({2'b00, eps_reg});
    assign neps18  = -eps18;
    assign stat18  = $signed({2'b00, stat_reg});
    assign nstat18 = -stat18;
    assign inc18   = $signed({2'b00, inc_reg});
    assign ninc18  = -inc18;
    assign thr18   = $signed({2'b00, thr_reg});
    assign nthr18  = -thr18;
    assign inband  = (err18 >= neps18) && (err18 <= eps18);
    assign ge_eps  = err18 >= eps18;
    assign le_neps = err18 <= neps18;

    // ------------------------------------------------------------------
    // Mode machine and integrator for a control step
    // ------------------------------------------------------------------
    mode_code_t         st_mode;
    logic signed [31:0] st_sum;
    logic               st_dba;
    logic [15:0]        st_settle, settle_inc;
    logic signed [31:0] sum_base;
    logic signed [17:0] sum_add;
    logic signed [33:0] sum_wide;
    logic signed [31:0] sum_sat;

    // Pick the integrator base and capped increment by direction
    always_comb
    begin
        if (mode_reg == MODE_BELOW)
        begin
            sum_base = error_sum_reg[31] ? 32'sd0 : error_sum_reg;
            sum_add  = (err18 < inc18) ? err18 : inc18;
        end
        else
        begin
            sum_base = error_sum_reg[31] ? error_sum_reg : 32'sd0;
            sum_add  = (err18 > ninc18) ? err18 : ninc18;
        end
        sum_wide = 34'(sum_base) + 34'(sum_add);
        if (sum_wide[33:31] != 3'b000 && sum_wide[33:31] != 3'b111)
            sum_sat = sum_wide[33] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        else
            sum_sat = sum_wide[31:0];
        settle_inc = (settle_reg != 16'hFFFF) ? settle_reg + 16'd1 : settle_reg;
    end

    // Advance the band mode machine
    always_comb
    begin
        st_mode   = mode_reg;
        st_sum    = error_sum_reg;
        st_dba    = dba_reg;
        st_settle = settle_reg;
        unique case (mode_reg)
            MODE_INIT:
            begin
                if (le_neps)
                    st_mode = MODE_ABOVE;
                else if (ge_eps)
                    st_mode = MODE_BELOW;
                else
                begin
                    st_mode   = MODE_ONTGT;
                    st_settle = '0;
                end
            end
            MODE_BELOW:
            begin
                st_sum = sum_sat;
                if (err18 >= stat18)
                    st_dba = 1'b0;
                if (inband)
                begin
                    st_mode   = MODE_ONTGT;
                    st_settle = '0;
                end
                else if (le_neps)
                begin
                    st_mode = MODE_ABOVE;
                    st_sum  = '0;
                end
            end
            MODE_ABOVE:
            begin
                st_sum = sum_sat;
                if (err18 <= nstat18)
                    st_dba = 1'b0;
                if (inband)
                begin
                    st_mode   = MODE_ONTGT;
                    st_settle = '0;
                end
                else if (ge_eps)
                begin
                    st_mode = MODE_BELOW;
                    st_sum  = '0;
                end
            end
            MODE_ONTGT:
            begin
                st_sum = '0;
                st_dba = 1'b1;
                if (ge_eps)
                begin
                    st_mode   = MODE_BELOW;
                    st_settle = '0;
                end
                else if (le_neps)
                begin
                    st_mode   = MODE_ABOVE;
                    st_settle = '0;
                end
                else if (settle_inc >= steps_reg)
                begin
                    st_mode   = MODE_STAB;
                    st_settle = '0;
                end
                else
                    st_settle = settle_inc;
            end
            MODE_STAB:
            begin
                st_sum = '0;
                st_dba = 1'b1;
                if (ge_eps)
                    st_mode = MODE_BELOW;
                else if (le_neps)
                    st_mode = MODE_ABOVE;
            end
            default:
            begin
                st_mode = MODE_DIS;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // P, I and D terms
    // ------------------------------------------------------------------
    logic signed [31:0] sum_used;
    logic signed [17:0] diff18;
    logic signed [32:0] p_prod;
    logic signed [47:0] i_prod;
    logic signed [35:0] d_prod;
    logic signed [39:0] i_sh, imax40, nimax40;
    logic signed [27:0] d_sh, band28, nband28;
    logic signed [17:0] i_term, d_term;
    logic signed [26:0] o_sum, out_min27, out_max27;
    logic [17:0]        err_mag;
    logic               dead_zero;
    logic signed [15:0] drive_c;

    // Drop the sum outside the threshold window
    assign sum_used = (thr_en_reg && (err18 > thr18 || err18 < nthr18)) ? 32'sd0 : st_sum;
    // No derivative kick on the initializing step
    assign diff18   = (mode_reg == MODE_INIT) ? 18'sd0 : err18 - 18'(last_error_reg);

    assign p_prod = gain_prop_reg * err;
    assign i_prod = gain_integ_reg * sum_used;
    assign d_prod = gain_deriv_reg * diff18;

    // Floor shift by eight, then clamp I and D
    assign i_sh    = i_prod[47:8];
    assign imax40  = $signed({24'd0, imax_reg});
    assign nimax40 = -imax40;
    assign d_sh    = d_prod[35:8];
    assign band28  = $signed({12'd0, band_reg});
    assign nband28 = -band28;

    always_comb
    begin
        if (i_sh > imax40)
            i_term = 18'(imax40);
        else if (i_sh < nimax40)
            i_term = 18'(nimax40);
        else
            i_term = 18'(i_sh);

        if (d_sh > band28)
            d_term = 18'(band28);
        else if (d_sh < nband28)
            d_term = 18'(nband28);
        else
            d_term = 18'(d_sh);
    end

    // Sum the terms, apply the static dead band and the output clamp
    assign err_mag   = err18[17] ? 18'(-err18) : 18'(err18);
    assign dead_zero = st_dba && (err_mag < {2'b00, stat_reg});
    assign out_min27 = 27'(out_min_reg);
    assign out_max27 = 27'(out_max_reg);

    always_comb
    begin
        o_sum = dead_zero ? 27'sd0
                          : 27'($signed(p_prod[32:8])) + 27'(i_term) + 27'(d_term);
        if (o_sum > out_max27)
            drive_c = out_max_reg;
        else if (o_sum < out_min27)
            drive_c = out_min_reg;
        else
            drive_c = 16'(o_sum);
    end

    // ------------------------------------------------------------------
    // Next state and result by item kind
    // ------------------------------------------------------------------
    logic signed [15:0] drive_next;
    logic               drive_valid_next;
    logic signed [16:0] err_out_next;

    always_comb
    begin
        mode_next        = mode_reg;
        error_sum_next   = error_sum_reg;
        last_error_next  = last_error_reg;
        dba_next         = dba_reg;
        settle_next      = settle_reg;
        drive_next       = '0;
        drive_valid_next = 1'b0;
        err_out_next     = last_error_reg;
        unique case (s1_kind_reg)
            KIND_ENABLE:
            begin
                if (mode_reg == MODE_DIS)
                    mode_next = MODE_INIT;
            end
            KIND_DISABLE:
            begin
                error_sum_next  = '0;
                last_error_next = '0;
                dba_next        = 1'b1;
                mode_next       = MODE_DIS;
                err_out_next    = '0;
            end
            KIND_CLEAR:
            begin
                error_sum_next = '0;
            end
            default:
            begin
                if (mode_reg == MODE_DIS)
                begin
                    error_sum_next  = '0;
                    last_error_next = '0;
                    dba_next        = 1'b1;
                    err_out_next    = '0;
                end
                else
                begin
                    mode_next        = st_mode;
                    error_sum_next   = dead_zero ? 32'sd0 : sum_used;
                    dba_next         = st_dba;
                    settle_next      = st_settle;
                    last_error_next  = err;
                    err_out_next     = err;
                    drive_next       = drive_c;
                    drive_valid_next = 1'b1;
                end
            end
        endcase
    end

    // Commit state when the item moves into the result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= MODE_INIT;
            error_sum_reg  <= '0;
            last_error_reg <= '0;
            dba_reg        <= 1'b0;
            settle_reg     <= '0;
        end
        else if (s1_valid_reg && advance)
        begin
            mode_reg       <= mode_next;
            error_sum_reg  <= error_sum_next;
            last_error_reg <= last_error_next;
            dba_reg        <= dba_next;
            settle_reg     <= settle_next;
        end
    end

    // ------------------------------------------------------------------
    // Result register
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_valid_reg && advance)
        begin
            drive       <= drive_next;
            drive_valid <= drive_valid_next;
            error_now   <= err_out_next;
            at_target   <= (mode_next == MODE_ONTGT) || (mode_next == MODE_STAB);
            stabilized  <= mode_next == MODE_STAB;
            enabled     <= mode_next != MODE_DIS;
        end
    end

    assign out_valid = out_valid_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_stall_needs_item: assert property (
        @(posedge clk) disable iff (!rst_n)
        in_stall |-> s1_valid_reg)
        else $error("input stalled with an empty input register");

    a_stab_is_at_target: assert property (
        @(posedge clk) disable iff (!rst_n)
        out_valid_reg && stabilized |-> at_target)
        else $error("stabilized result without at_target");

    a_drive_needs_enable: assert property (
        @(posedge clk) disable iff (!rst_n)
        out_valid_reg && drive_valid |-> enabled)
        else $error("new drive reported while disabled");

    a_idle_drive_zero: assert property (
        @(posedge clk) disable iff (!rst_n)
        out_valid_reg && !drive_valid |-> drive == 16'sd0)
        else $error("nonzero drive without drive_valid");

    a_disable_commits: assert property (
        @(posedge clk) disable iff (!rst_n)
        s1_valid_reg && advance && s1_kind_reg == KIND_DISABLE |=> mode_reg == MODE_DIS)
        else $error("disable transfer did not reach the disabled mode");

endmodule : banded_pid_controller_unit

`default_nettype wire

>>> tb/tb_banded_pid_controller_unit.sv
// ============================================================================
// tb_banded_pid_controller_unit: self-checking bench for the banded PID unit
// Drives control steps, enable, disable and clear items through the
// valid/stall input channel and checks every result against a cycle-free
// predictor of the controller (mode machine, anti-windup sum, P + I + D,
// dead band and clamps). Several register settings are exercised, the
// extremes among them, with random idling on both channels.
// ============================================================================

module tb_banded_pid_controller_unit
    import bpid_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int     WATCHDOG_LIMIT = 2000;
    localparam int     RX_HOLD_CYCLES = 50;
    localparam longint SUM_MAX        = 64'sd2147483647;
    localparam longint SUM_MIN        = -64'sd2147483648;

    // register setting styles for a phase
    localparam int CFG_DIRECTED = 0;
    localparam int CFG_HIGH     = 1;
    localparam int CFG_LOW      = 2;
    localparam int CFG_RANDOM   = 3;

    // one result of the block, fields at port widths
    typedef struct packed {
        logic [15:0] drive;
        logic        drive_valid;
        logic [16:0] error_now;
        logic        at_target;
        logic        stabilized;
        logic        enabled;
    } step_result_t;

    // ------------------------------------------------------------------------
    // Scoreboard: mirror of the registers and controller state, and the
    // results still owed by the block, oldest first
    // ------------------------------------------------------------------------
    class pid_scoreboard;
        logic signed [15:0] gain_p, gain_i, gain_d;
        logic [15:0]        eps, dead_band, integ_max, integ_thr;
        logic               thr_enable;
        logic signed [15:0] drive_lo, drive_hi, meas_lo, meas_hi;
        logic [15:0]        deriv_band, settle_steps, inc_cap;

        mode_code_t         mode;
        longint             err_sum;
        longint             prev_err;
        bit                 dead_band_ok;
        int unsigned        settle_cnt;

        step_result_t       results_due[$];
        int                 mismatches;

        function new();
            gain_p       = '0;
            gain_i       = '0;
            gain_d       = '0;
            eps          = '0;
            dead_band    = '0;
            integ_max    = RST_IMAX;
            integ_thr    = '0;
            thr_enable   = 1'b0;
            drive_lo     = RST_RANGE_LO;
            drive_hi     = RST_RANGE_HI;
            meas_lo      = RST_RANGE_LO;
            meas_hi      = RST_RANGE_HI;
            deriv_band   = RST_BAND;
            settle_steps = RST_STEPS;
            inc_cap      = RST_INC_CAP;
            mode         = MODE_INIT;
            err_sum      = 0;
            prev_err     = 0;
            dead_band_ok = 1'b0;
            settle_cnt   = 0;
            mismatches   = 0;
        endfunction

        function longint bound(longint v, longint lo, longint hi);
            if (v > hi)
                return hi;
            if (v < lo)
                return lo;
            return v;
        endfunction

        // mirror a register write; ranges with min >= max are dropped
        function void apply_config(reg_index_t idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_GAIN_PROP:  gain_p = data[15:0];
                REG_GAIN_INTEG: gain_i = data[15:0];
                REG_GAIN_DERIV: gain_d = data[15:0];
                REG_ERROR_BANDS:
                begin
                    eps       = data[15:0];
                    dead_band = data[31:16];
                end
                REG_INTEGRAL_LIMITS:
                begin
                    integ_max  = data[15:0];
                    integ_thr  = data[31:16];
                    thr_enable = data[32];
                end
                REG_OUTPUT_RANGE:
                begin
                    if ($signed(data[15:0]) < $signed(data[31:16]))
                    begin
                        drive_lo = data[15:0];
                        drive_hi = data[31:16];
                    end
                end
                REG_INPUT_RANGE:
                begin
                    if ($signed(data[15:0]) < $signed(data[31:16]))
                    begin
                        meas_lo = data[15:0];
                        meas_hi = data[31:16];
                    end
                end
                default:
                begin
                    deriv_band   = data[15:0];
                    settle_steps = data[31:16];
                    inc_cap      = data[47:32];
                end
            endcase
        endfunction

        // advance the controller by one accepted transfer and queue its result
        function void take_item(kind_code_t k, logic signed [15:0] meas,
                                logic signed [15:0] tgt);
            step_result_t r;
            longint       pv, err, eps_l, stat_l, inc_l, thr_l, p, ip, dp, total;
            bit           inband;
            mode_code_t   nm;

            r = '0;
            r.error_now = 17'(prev_err);
            case (k)
                KIND_ENABLE:
                begin
                    if (mode == MODE_DIS)
                        mode = MODE_INIT;
                end
                KIND_DISABLE:
                begin
                    err_sum      = 0;
                    prev_err     = 0;
                    dead_band_ok = 1'b1;
                    mode         = MODE_DIS;
                    r.error_now  = '0;
                end
                KIND_CLEAR:
                    err_sum = 0;
                default:
                begin
                    if (mode == MODE_DIS)
                    begin
                        // drop the step, keep the loop cleared
                        err_sum      = 0;
                        prev_err     = 0;
                        dead_band_ok = 1'b1;
                        r.error_now  = '0;
                    end
                    else
                    begin
                        eps_l  = eps;
                        stat_l = dead_band;
                        inc_l  = inc_cap;
                        thr_l  = integ_thr;
                        pv     = bound(longint'(meas), longint'(meas_lo), longint'(meas_hi));
                        err    = longint'(tgt) - pv;
                        inband = (err >= -eps_l) && (err <= eps_l);
                        nm     = mode;

                        // mode machine and anti-windup sum
                        case (mode)
                            MODE_INIT:
                            begin
                                prev_err = err;
                                if (err <= -eps_l)
                                    nm = MODE_ABOVE;
                                else if (err >= eps_l)
                                    nm = MODE_BELOW;
                                else
                                begin
                                    nm         = MODE_ONTGT;
                                    settle_cnt = 0;
                                end
                            end
                            MODE_BELOW:
                            begin
                                if (err_sum < 0)
                                    err_sum = 0;
                                err_sum = bound(err_sum + ((err < inc_l) ? err : inc_l),
                                                SUM_MIN, SUM_MAX);
                                if (err >= stat_l)
                                    dead_band_ok = 1'b0;
                                if (inband)
                                begin
                                    nm         = MODE_ONTGT;
                                    settle_cnt = 0;
                                end
                                else if (err <= -eps_l)
                                begin
                                    nm      = MODE_ABOVE;
                                    err_sum = 0;
                                end
                            end
                            MODE_ABOVE:
                            begin
                                if (err_sum > 0)
                                    err_sum = 0;
                                err_sum = bound(err_sum + ((err > -inc_l) ? err : -inc_l),
                                                SUM_MIN, SUM_MAX);
                                if (err <= -stat_l)
                                    dead_band_ok = 1'b0;
                                if (inband)
                                begin
                                    nm         = MODE_ONTGT;
                                    settle_cnt = 0;
                                end
                                else if (err >= eps_l)
                                begin
                                    nm      = MODE_BELOW;
                                    err_sum = 0;
                                end
                            end
                            MODE_ONTGT:
                            begin
                                err_sum      = 0;
                                dead_band_ok = 1'b1;
                                if (err >= eps_l)
                                begin
                                    nm         = MODE_BELOW;
                                    settle_cnt = 0;
                                end
                                else if (err <= -eps_l)
                                begin
                                    nm         = MODE_ABOVE;
                                    settle_cnt = 0;
                                end
                                else
                                begin
                                    if (settle_cnt < 16'hFFFF)
                                        settle_cnt++;
                                    if (settle_cnt >= settle_steps)
                                    begin
                                        nm         = MODE_STAB;
                                        settle_cnt = 0;
                                    end
                                end
                            end
                            MODE_STAB:
                            begin
                                err_sum      = 0;
                                dead_band_ok = 1'b1;
                                if (err >= eps_l)
                                    nm = MODE_BELOW;
                                else if (err <= -eps_l)
                                    nm = MODE_ABOVE;
                            end
                            default:
                                nm = MODE_DIS;
                        endcase
                        mode = nm;

                        // P + I + D with floor rounding, then dead band and clamp
                        p = (longint'(gain_p) * err) >>> 8;
                        if (thr_enable && (err > thr_l || err < -thr_l))
                            err_sum = 0;
                        ip = bound((longint'(gain_i) * err_sum) >>> 8,
                                   -longint'(integ_max), longint'(integ_max));
                        dp = bound((longint'(gain_d) * (err - prev_err)) >>> 8,
                                   -longint'(deriv_band), longint'(deriv_band));
                        total = p + ip + dp;
                        if (dead_band_ok && ((err < 0) ? -err : err) < stat_l)
                        begin
                            total   = 0;
                            err_sum = 0;
                        end
                        r.drive       = 16'(bound(total, longint'(drive_lo),
                                                  longint'(drive_hi)));
                        r.drive_valid = 1'b1;
                        prev_err      = err;
                        r.error_now   = 17'(err);
                    end
                end
            endcase
            r.at_target  = (mode == MODE_ONTGT) || (mode == MODE_STAB);
            r.stabilized = (mode == MODE_STAB);
            r.enabled    = (mode != MODE_DIS);
            results_due.push_back(r);
        endfunction

        function void check_field(string name, logic [16:0] want, logic [16:0] got);
            if (got !== want)
            begin
                $display("%0t: %s mismatch: expected %h actual %h", $time, name, want, got);
                mismatches++;
            end
        endfunction

        // compare one result transfer against the oldest owed result
        function void check_result(logic [15:0] d, logic dv, logic [16:0] e,
                                   logic ot, logic st, logic en);
            step_result_t want;
            if (results_due.size() == 0)
            begin
                $display("%0t: result transfer with none outstanding: drive %h error %h",
                         $time, d, e);
                mismatches++;
            end
            else
            begin
                want = results_due.pop_front();
                check_field("drive", 17'(want.drive), 17'(d));
                check_field("drive_valid", 17'(want.drive_valid), 17'(dv));
                check_field("error_now", want.error_now, e);
                check_field("at_target", 17'(want.at_target), 17'(ot));
                check_field("stabilized", 17'(want.stabilized), 17'(st));
                check_field("enabled", 17'(want.enabled), 17'(en));
            end
        endfunction

        function void close_out();
            if (results_due.size() != 0)
            begin
                $display("%0t: %0d results never arrived", $time, results_due.size());
                mismatches++;
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Signals and block
    // ------------------------------------------------------------------------
    logic                  clk;
    logic                  rst_n;
    logic                  cfg_write;
    reg_index_t            cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  in_valid;
    logic                  in_stall;
    kind_code_t            kind;
    logic signed [15:0]    measured;
    logic signed [15:0]    target;
    logic                  out_valid;
    logic                  out_stall;
    logic signed [15:0]    drive;
    logic                  drive_valid;
    logic signed [16:0]    error_now;
    logic                  at_target;
    logic                  stabilized;
    logic                  enabled;

    pid_scoreboard         sb = new();
    bit                    tx_idle_on = 1'b1;
    bit                    rx_idle_on = 1'b1;
    bit                    rx_hold_req = 1'b0;
    logic signed [15:0]    setpoint = '0;
    int                    quiet_cycles = 0;

    banded_pid_controller_unit u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_write),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .kind        (kind),
        .measured    (measured),
        .target      (target),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .drive       (drive),
        .drive_valid (drive_valid),
        .error_now   (error_now),
        .at_target   (at_target),
        .stabilized  (stabilized),
        .enabled     (enabled)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Monitor: check result transfers, predict from input transfers
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
                sb.check_result(drive, drive_valid, error_now, at_target, stabilized, enabled);
            if (in_valid && !in_stall)
                sb.take_item(kind, measured, target);
        end
    end

    // Watchdog: end the run after a long stretch with no transfer or write
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_write)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Receiver: random stall bursts, and one long hold-off on request
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rx_hold_req)
            begin
                rx_hold_req = 1'b0;
                out_stall <= 1'b1;
                repeat (RX_HOLD_CYCLES) @(posedge clk);
                out_stall <= 1'b0;
            end
            else if (rx_idle_on && $urandom_range(0, 5) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 11)) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Driving tasks
    // ------------------------------------------------------------------------
    function automatic int pick_gap(bit allow);
        if (allow && tx_idle_on && $urandom_range(0, 4) == 0)
            return int'($urandom_range(1, 11));
        return 0;
    endfunction

    // offer one item after an optional idle gap; return once it transfers
    task automatic send_item(kind_code_t k, logic [15:0] m, logic [15:0] t, int gap);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        kind     <= k;
        measured <= m;
        target   <= t;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    // stop offering and hold until every owed result has transferred
    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.results_due.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(reg_index_t idx, logic [CFG_DATA_W-1:0] data);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        sb.apply_config(idx, data);
    endtask

    function automatic logic [15:0] pick_gain();
        int roll;
        roll = $urandom_range(0, 5);
        if (roll == 0)
            return 16'h7FFF;
        if (roll == 1)
            return 16'h8000;
        return 16'(int'($urandom_range(0, 16'h0C00)) - 16'h0600);
    endfunction

    // write all registers for one phase; the block must be idle
    task automatic load_config(int style);
        logic [15:0] gp, gi, gd;
        logic [31:0] bands, orange, irange;
        logic [32:0] ilim;
        logic [47:0] slim;
        logic [47:0] junk;

        junk = 48'({$urandom, $urandom});
        case (style)
            CFG_DIRECTED:
            begin
                gp     = 16'h0100;
                gi     = 16'h0080;
                gd     = 16'h0200;
                bands  = {16'h0040, 16'h0100};
                ilim   = {1'b1, 16'h2000, 16'h0800};
                orange = {16'h0800, 16'hF800};
                irange = {16'h2000, 16'hE000};
                slim   = {16'h0050, 16'd3, 16'h0400};
            end
            CFG_HIGH:
            begin
                gp     = 16'h7FFF;
                gi     = 16'h7FFF;
                gd     = 16'h7FFF;
                bands  = 32'hFFFF_FFFF;
                ilim   = 33'h1_FFFF_FFFF;
                orange = {16'h7FFF, 16'h8000};
                irange = {16'h7FFF, 16'h8000};
                slim   = 48'hFFFF_FFFF_FFFF;
            end
            CFG_LOW:
            begin
                gp     = 16'h8000;
                gi     = 16'h8000;
                gd     = 16'h8000;
                bands  = '0;
                ilim   = '0;
                orange = {16'h7FFF, 16'h7FFE};
                irange = {16'h8001, 16'h8000};
                slim   = '0;
            end
            default:
            begin
                gp     = pick_gain();
                gi     = pick_gain();
                gd     = pick_gain();
                bands  = {16'($urandom_range(0, 16'h0100)), 16'($urandom_range(0, 16'h0200))};
                ilim   = {1'($urandom_range(0, 1)), 16'($urandom_range(0, 16'h6000)),
                          16'($urandom_range(0, 16'h4000))};
                orange = {16'($urandom_range(16'h0100, 16'h4000)),
                          16'(32'h10000 - $urandom_range(16'h0100, 16'h4000))};
                irange = {16'($urandom_range(16'h0400, 16'h7FFF)),
                          16'(32'h10000 - $urandom_range(16'h0400, 16'h7FFF))};
                slim   = {16'($urandom_range(0, 16'h0200)), 16'($urandom_range(0, 6)),
                          16'($urandom_range(0, 16'h2000))};
            end
        endcase

        // unused upper data bits carry noise; the block must ignore them
        write_reg(REG_GAIN_PROP, {junk[47:16], gp});
        write_reg(REG_GAIN_INTEG, {junk[47:16], gi});
        write_reg(REG_GAIN_DERIV, {junk[47:16], gd});
        write_reg(REG_ERROR_BANDS, {junk[47:32], bands});
        write_reg(REG_INTEGRAL_LIMITS, {junk[47:33], ilim});
        write_reg(REG_OUTPUT_RANGE, {junk[47:32], orange});
        write_reg(REG_INPUT_RANGE, {junk[47:32], irange});
        write_reg(REG_STEP_LIMITS, slim);
        if (style != CFG_RANDOM || $urandom_range(0, 3) == 0)
        begin
            // rejected range writes: equal bounds, then swapped bounds
            write_reg(REG_OUTPUT_RANGE, {junk[47:32], orange[31:16], orange[31:16]});
            write_reg(REG_INPUT_RANGE, {junk[47:32], irange[15:0], irange[31:16]});
        end
        cfg_write <= 1'b0;
    endtask

    // mostly control steps tracking a drifting setpoint, with calm runs
    // inside the target band and occasional mode commands and wild samples
    task automatic send_random(int count, bit allow_gaps);
        kind_code_t  k;
        logic [15:0] m, t;
        int          pick, roll, span, offset, calm_left;

        calm_left = 0;
        repeat (count)
        begin
            pick = $urandom_range(0, 99);
            if (sb.mode == MODE_DIS && pick < 50)
                k = KIND_ENABLE;
            else if (pick < 3)
                k = KIND_DISABLE;
            else if (pick < 7)
                k = KIND_CLEAR;
            else if (pick < 11)
                k = KIND_ENABLE;
            else
                k = KIND_STEP;

            if ($urandom_range(0, 19) == 0)
                setpoint = ($urandom_range(0, 3) == 0) ? 16'($urandom)
                         : 16'(int'($urandom_range(0, 16'h6000)) - 16'h3000);
            if (calm_left == 0 && $urandom_range(0, 24) == 0)
                calm_left = $urandom_range(4, 12);
            roll = $urandom_range(0, 9);
            if (calm_left > 0)
            begin
                calm_left--;
                roll = 0;
            end
            span   = (roll < 4) ? int'(sb.eps) : 16'h1800;
            offset = int'($urandom_range(0, 2 * span)) - span;
            t      = setpoint;
            m      = 16'(int'(setpoint) - offset);
            if (roll == 9)
                m = 16'($urandom);
            if ($urandom_range(0, 15) == 0)
                t = 16'($urandom);
            send_item(k, m, t, pick_gap(allow_gaps));
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        int phase;
        bit last;

        rst_n     = 1'b0;
        cfg_write = 1'b0;
        cfg_index = REG_GAIN_PROP;
        cfg_data  = '0;
        in_valid  = 1'b0;
        kind      = KIND_STEP;
        measured  = '0;
        target    = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // zero error under the reset zero epsilon counts as above target
        send_item(KIND_STEP, 16'h0000, 16'h0000, pick_gap(1));
        drain_results();
        load_config(CFG_DIRECTED);

        // return to initialize, then settle, leave the band both ways
        send_item(KIND_DISABLE, 16'h0000, 16'h0000, pick_gap(1));
        send_item(KIND_ENABLE, 16'hFFFF, 16'hFFFF, pick_gap(1));
        send_item(KIND_STEP, 16'h0000, 16'h0000, pick_gap(1));
        send_item(KIND_STEP, 16'h0010, 16'h0000, pick_gap(1));
        send_item(KIND_STEP, 16'h0000, 16'h0020, pick_gap(1));
        send_item(KIND_STEP, 16'h0000, 16'h0000, pick_gap(1));
        send_item(KIND_STEP, 16'h0000, 16'h0800, pick_gap(1));
        send_item(KIND_STEP, 16'h0000, 16'h0900, pick_gap(1));
        send_item(KIND_STEP, 16'h0100, 16'h0C00, pick_gap(1));
        // beyond the error threshold, then a sign reversal
        send_item(KIND_STEP, 16'h0000, 16'h3000, pick_gap(1));
        send_item(KIND_STEP, 16'h0800, 16'h0000, pick_gap(1));
        send_item(KIND_STEP, 16'h0900, 16'h0000, pick_gap(1));
        // back on target inside the static dead band
        send_item(KIND_STEP, 16'h0000, 16'h0020, pick_gap(1));
        send_item(KIND_STEP, 16'h0000, 16'h0030, pick_gap(1));
        // field extremes, measurement clamped by the input range
        send_item(KIND_STEP, 16'h7FFF, 16'h8000, pick_gap(1));
        send_item(KIND_STEP, 16'h8000, 16'h7FFF, pick_gap(1));
        send_item(KIND_CLEAR, 16'hA5A5, 16'h5A5A, pick_gap(1));
        send_item(KIND_ENABLE, 16'h0000, 16'h0000, pick_gap(1));
        send_item(KIND_DISABLE, 16'h0000, 16'h0000, pick_gap(1));
        send_item(KIND_STEP, 16'h1234, 16'h4321, pick_gap(1));
        send_item(KIND_CLEAR, 16'h0000, 16'h0000, pick_gap(1));
        send_item(KIND_ENABLE, 16'h0000, 16'h0000, pick_gap(1));
        send_item(KIND_STEP, 16'h0000, 16'h0000, pick_gap(1));
        drain_results();

        for (phase = 0; phase < 6; phase++)
        begin
            last       = (phase == 5);
            tx_idle_on = !last && ($urandom_range(0, 3) != 0);
            rx_idle_on = !last && ($urandom_range(0, 3) != 0);
            if (phase == 0)
                load_config(CFG_HIGH);
            else if (phase == 1)
                load_config(CFG_LOW);
            else
                load_config(CFG_RANDOM);

            if (phase == 2)
            begin
                // long receiver hold-off while items keep coming
                send_random(60, 1'b1);
                rx_hold_req = 1'b1;
                send_random(30, 1'b0);
                send_random(50, 1'b1);
            end
            else if (phase == 3)
            begin
                // pause the sender until the block has emptied
                send_random(70, 1'b1);
                drain_results();
                send_random(70, 1'b1);
            end
            else
                send_random((phase < 2) ? 80 : 140, 1'b1);
            drain_results();
        end

        // allow for any stray result past the pipeline depth
        repeat (4) @(posedge clk);
        sb.close_out();
        if (sb.mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule : tb_banded_pid_controller_unit
